/* rtl/cfd_pkg.sv */
// package: shared constants and types for the command frame deframer
`timescale 1ns / 1ps
package cfd_pkg;

  localparam int FRAME_LEN = 8;
  localparam int HELD_W = $clog2(FRAME_LEN);
  localparam logic [HELD_W-1:0] HELD_LAST = HELD_W'(FRAME_LEN - 1);

  localparam logic [7:0] HEADER_RESET = 8'h5A;
  localparam logic [7:0] TAIL_RESET = 8'hA5;

  localparam int QUEUE_DEPTH_DEF = 2;

  localparam logic REG_HEADER = 1'b0;
  localparam logic REG_TAIL = 1'b1;

  typedef struct packed {
    logic [7:0] flag_bits;
    logic signed [15:0] turn_cmd;
    logic signed [15:0] speed_cmd;
  } cmd_t;

endpackage

/* rtl/cfd_front.sv */
// front end: byte window, frame check and configuration registers
`timescale 1ns / 1ps
module cfd_front
  import cfd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic       cfg_addr,
  input  logic [7:0] cfg_wdata,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,
  input  logic       q_full,
  output logic       push,
  output cmd_t       push_cmd
);

  logic [7:0] header_r;
  logic [7:0] tail_r;
  logic [7:0] win_r [FRAME_LEN-1];
  logic [HELD_W-1:0] held_r;
  logic [HELD_W-1:0] held_nxt;
  logic acc;
  logic [7:0] sum;
  logic frame_ok;

  assign in_tready = !q_full;
  assign acc = in_tvalid && in_tready;

  assign sum = win_r[1] + win_r[2] + win_r[3] + win_r[4] + win_r[5];
  assign frame_ok = (win_r[0] == header_r) && (in_tdata == tail_r) && (sum == win_r[6]);

  assign push = acc && (held_r == HELD_LAST) && frame_ok;
  assign push_cmd.speed_cmd = {win_r[2], win_r[1]};
  assign push_cmd.turn_cmd = {win_r[4], win_r[3]};
  assign push_cmd.flag_bits = win_r[5];

  always_comb begin
    held_nxt = held_r;
    if (acc) begin
      if (held_r != HELD_LAST) begin
        held_nxt = held_r + 1'b1;
      end else if (frame_ok) begin
        held_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= '0;
      header_r <= HEADER_RESET;
      tail_r <= TAIL_RESET;
    end else begin
      held_r <= held_nxt;
      if (cfg_we) begin
        unique case (cfg_addr)
          REG_HEADER: header_r <= cfg_wdata;
          REG_TAIL:   tail_r <= cfg_wdata;
          default:    ;
        endcase
      end
    end
  end

  // window shifts down on a failed full check
  always_ff @(posedge clk) begin
    if (acc) begin
      if (held_r != HELD_LAST) begin
        win_r[held_r] <= in_tdata;
      end else if (!frame_ok) begin
        for (int i = 0; i < FRAME_LEN - 2; i++) begin
          win_r[i] <= win_r[i+1];
        end
        win_r[FRAME_LEN-2] <= in_tdata;
      end
    end
  end

`ifndef SYNTHESIS
  a_held_step: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && held_r != HELD_LAST) |=> held_r == $past(held_r) + 1'b1)
    else $error("held count did not advance");
  a_full_stay: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && held_r == HELD_LAST && !frame_ok) |=> held_r == HELD_LAST)
    else $error("failed frame did not keep window full");
`endif

endmodule

/* rtl/cfd_queue.sv */
// result queue between front and back
`timescale 1ns / 1ps
module cfd_queue
  import cfd_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic q_valid,
  output cmd_t q_cmd
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  cmd_t mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic do_pop;

  assign full = (count_r == CNT_FULL);
  assign q_valid = (count_r != '0);
  assign q_cmd = mem[rd_ptr_r];
  assign do_pop = pop && q_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_cmd;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full && !do_pop))
    else $error("push into full queue");
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_FULL)
    else $error("queue count out of range");
`endif

endmodule

/* rtl/cfd_back.sv */
// back end: output register feeding the result stream
`timescale 1ns / 1ps
module cfd_back
  import cfd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_valid,
  input  cmd_t        q_cmd,
  output logic        pop,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata
);

  logic out_valid_r;
  cmd_t out_cmd_r;

  assign pop = q_valid && (!out_valid_r || out_tready);
  assign out_tvalid = out_valid_r;
  assign out_tdata = {out_cmd_r.flag_bits, out_cmd_r.turn_cmd, out_cmd_r.speed_cmd};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || out_tready) begin
      out_valid_r <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_cmd_r <= q_cmd;
    end
  end

endmodule

/* rtl/command_frame_deframer.sv */
// a good frame's result enters the queue as its tail beat is accepted, then moves to the output register
// throughput: one byte beat per cycle, stalled only while the result queue is full
// a result waits in a queue of QUEUE_DEPTH entries plus one output register
// reset: synchronous active low; clears the held count, queue and output valid,
// and restores header 0x5A and tail 0xA5
`timescale 1ns / 1ps
module command_frame_deframer
  import cfd_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [7:0]  cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // rx_byte[7:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata   // speed_cmd[15:0], turn_cmd[31:16], flag_bits[39:32]
);

  logic push;
  cmd_t push_cmd;
  logic q_full;
  logic q_valid;
  cmd_t q_cmd;
  logic pop;

  cfd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_full    (q_full),
    .push      (push),
    .push_cmd  (push_cmd)
  );

  cfd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (pop),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd)
  );

  cfd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_cmd      (q_cmd),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

/* verif/cfd_checker.sv */
// checker: predicts command results from accepted byte beats and compares result beats
`timescale 1ns / 1ps
module cfd_checker
  import cfd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [7:0]  cfg_wdata,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [39:0] out_tdata,
  output int          fail_count,
  output int          outstanding
);

  logic [7:0] exp_header;
  logic [7:0] exp_tail;
  logic [7:0] window[FRAME_LEN];
  int         held;
  cmd_t       pending_cmds[$];

  task automatic absorb_byte(input logic [7:0] b);
    logic [7:0] sum;
    cmd_t       cmd;
    if (held >= FRAME_LEN) held = FRAME_LEN - 1;
    window[held] = b;
    held++;
    if (held == FRAME_LEN) begin
      sum = window[1] + window[2] + window[3] + window[4] + window[5];
      if (window[0] == exp_header && window[FRAME_LEN-1] == exp_tail && sum == window[6]) begin
        cmd.speed_cmd = {window[2], window[1]};
        cmd.turn_cmd  = {window[4], window[3]};
        cmd.flag_bits = window[5];
        pending_cmds.push_back(cmd);
        held = 0;
      end else begin
        for (int k = 0; k < FRAME_LEN - 1; k++) window[k] = window[k+1];
        held = FRAME_LEN - 1;
      end
    end
  endtask

  task automatic check_cmd(input cmd_t got);
    cmd_t want;
    if (pending_cmds.size() == 0) begin
      $error("result beat with no frame pending: %h", got);
      fail_count++;
    end else begin
      want = pending_cmds.pop_front();
      if (got.speed_cmd !== want.speed_cmd) begin
        $error("speed_cmd mismatch: expected %0d, got %0d", want.speed_cmd, got.speed_cmd);
        fail_count++;
      end
      if (got.turn_cmd !== want.turn_cmd) begin
        $error("turn_cmd mismatch: expected %0d, got %0d", want.turn_cmd, got.turn_cmd);
        fail_count++;
      end
      if (got.flag_bits !== want.flag_bits) begin
        $error("flag_bits mismatch: expected %h, got %h", want.flag_bits, got.flag_bits);
        fail_count++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      exp_header = HEADER_RESET;
      exp_tail = TAIL_RESET;
      held = 0;
      pending_cmds.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          REG_HEADER: exp_header = cfg_wdata;
          REG_TAIL:   exp_tail = cfg_wdata;
        endcase
      end
      if (out_tvalid && out_tready) check_cmd(out_tdata);
      if (in_tvalid && in_tready) absorb_byte(in_tdata);
    end
    outstanding = pending_cmds.size();
  end

endmodule

/* verif/testbench.sv */
// testbench top: byte stream stimulus, receiver stalls, watchdog and verdict
`timescale 1ns / 1ps
module testbench;
  import cfd_pkg::*;

  localparam int IDLE_LIMIT = 4000;
  localparam int HOLD_CYCLES = 200;
  localparam int SETTLE_CYCLES = 10;

  typedef enum int {CORRUPT_NONE, CORRUPT_HEADER, CORRUPT_TAIL, CORRUPT_SUM} corrupt_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic        cfg_addr = 1'b0;
  logic [7:0]  cfg_wdata = 8'h00;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;
  logic        hold_req = 1'b0;
  bit          hold_done = 1'b0;

  int          fail_count;
  int          outstanding;
  int          idle_cycles = 0;
  int          burst_left = 0;
  bit          gaps_on = 1'b1;
  int          bytes_sent = 0;
  logic [7:0]  cur_hdr = HEADER_RESET;
  logic [7:0]  cur_tl = TAIL_RESET;

  always #2 clk = ~clk;

  command_frame_deframer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  cfd_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .fail_count (fail_count),
    .outstanding(outstanding)
  );

  // receiver stall pattern, with one long hold-off on request
  initial begin
    int mode;
    int mode_left;
    mode = 0;
    mode_left = 0;
    @(posedge clk);
    forever begin
      if (hold_req && !hold_done) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end else begin
        if (mode_left == 0) begin
          mode = $urandom_range(0, 3);
          mode_left = $urandom_range(5, 60);
        end
        mode_left--;
        case (mode)
          0: out_tready <= 1'b1;
          1: out_tready <= 1'($urandom_range(0, 1));
          2: out_tready <= ($urandom_range(0, 3) == 0);
          default: out_tready <= (mode_left % 3 != 0);
        endcase
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  task automatic send_byte(input logic [7:0] b);
    int   gap;
    logic ready_seen;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if (gaps_on) begin
        gap = $urandom_range(1, 6);
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata <= b;
    ready_seen = 1'b0;
    while (!ready_seen) begin
      @(negedge clk);
      ready_seen = in_tready;
      @(posedge clk);
    end
    bytes_sent++;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic addr, input logic [7:0] value);
    in_tvalid <= 1'b0;
    wait_drained();
    cfg_we <= 1'b1;
    cfg_addr <= addr;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // content byte that often looks like a frame marker
  function automatic logic [7:0] content_byte();
    case ($urandom_range(0, 7))
      0: return cur_hdr;
      1: return cur_tl;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [15:0] content_word();
    case ($urandom_range(0, 9))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'h0000;
      3: return 16'hFFFF;
      default: return {content_byte(), content_byte()};
    endcase
  endfunction

  task automatic send_frame(input logic [15:0] speed, input logic [15:0] turn,
                            input logic [7:0] flags, input corrupt_t corrupt, input int keep);
    logic [7:0] fb[FRAME_LEN];
    fb[0] = cur_hdr;
    fb[1] = speed[7:0];
    fb[2] = speed[15:8];
    fb[3] = turn[7:0];
    fb[4] = turn[15:8];
    fb[5] = flags;
    fb[6] = fb[1] + fb[2] + fb[3] + fb[4] + fb[5];
    fb[7] = cur_tl;
    case (corrupt)
      CORRUPT_HEADER: fb[0] = fb[0] ^ 8'($urandom_range(1, 255));
      CORRUPT_TAIL:   fb[7] = fb[7] ^ 8'($urandom_range(1, 255));
      CORRUPT_SUM:    fb[6] = fb[6] ^ 8'($urandom_range(1, 255));
      default: ;
    endcase
    for (int k = 0; k < keep; k++) send_byte(fb[k]);
  endtask

  task automatic send_random_unit();
    int pick;
    int n;
    pick = $urandom_range(0, 9);
    if (pick <= 5) begin
      send_frame(content_word(), content_word(), content_byte(), CORRUPT_NONE, FRAME_LEN);
    end else if (pick == 6) begin
      send_frame(content_word(), content_word(), content_byte(),
                 corrupt_t'($urandom_range(CORRUPT_HEADER, CORRUPT_SUM)), FRAME_LEN);
    end else if (pick == 7) begin
      n = $urandom_range(1, 5);
      repeat (n) send_byte(8'($urandom_range(0, 255)));
    end else if (pick == 8) begin
      send_frame(content_word(), content_word(), content_byte(), CORRUPT_NONE,
                 $urandom_range(1, FRAME_LEN - 1));
    end else begin
      n = $urandom_range(1, 3);
      repeat (n) send_byte(content_byte());
    end
  endtask

  task automatic run_phase(input logic [7:0] hdr, input logic [7:0] tl, input int nbytes,
                           input bit pressure);
    int stop_at;
    write_reg(REG_HEADER, hdr);
    write_reg(REG_TAIL, tl);
    cur_hdr = hdr;
    cur_tl = tl;
    gaps_on = $urandom_range(0, 1);
    stop_at = bytes_sent + nbytes;
    if (pressure) begin
      gaps_on = 1'b0;
      hold_req <= 1'b1;
      repeat (8) send_frame(content_word(), content_word(), content_byte(), CORRUPT_NONE,
                            FRAME_LEN);
      gaps_on = 1'b1;
    end
    while (bytes_sent < stop_at) send_random_unit();
  endtask

  initial begin
    int stop_at;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: garbage ahead of a frame, field extremes, a bad checksum
    send_byte(8'hFF);
    send_frame(16'h7FFF, 16'h8000, 8'hFF, CORRUPT_NONE, FRAME_LEN);
    send_frame(16'h1234, 16'h5678, 8'h9A, CORRUPT_SUM, FRAME_LEN);
    send_frame(16'h8000, 16'h7FFF, 8'h00, CORRUPT_NONE, FRAME_LEN);

    stop_at = bytes_sent + 60;
    while (bytes_sent < stop_at) send_random_unit();

    run_phase(8'h00, 8'hFF, 80, 1'b0);
    run_phase(8'hFF, 8'h00, 80, 1'b1);
    run_phase(8'h77, 8'h77, 70, 1'b0);
    run_phase(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 80, 1'b0);
    run_phase(HEADER_RESET, TAIL_RESET, 60, 1'b0);

    in_tvalid <= 1'b0;
    wait_drained();
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

/* command_frame_deframer.f */
rtl/cfd_pkg.sv
rtl/cfd_front.sv
rtl/cfd_queue.sv
rtl/cfd_back.sv
rtl/command_frame_deframer.sv
verif/cfd_checker.sv
verif/testbench.sv
